// ----- sv/mbm_pkg.sv -----
package mbm_pkg;

	localparam int FRAC_BITS  = 26;
	localparam int Q_W        = 32;
	localparam int IDX_W      = 10;
	localparam int STEP_W     = 31;
	localparam int ITER_W     = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = 2 * Q_W;
	localparam int SQ_W       = PROD_W - FRAC_BITS;
	localparam int ACC_W      = 42;

	localparam int IMAGE_WIDTH_DEF  = 1024;
	localparam int IMAGE_HEIGHT_DEF = 1024;
	localparam int QUEUE_DEPTH_DEF  = 2;

	localparam logic signed [Q_W-1:0] X_ORIGIN_RST = 32'shFA00_0000;
	localparam logic signed [Q_W-1:0] Y_ORIGIN_RST = 32'shFC00_0000;
	localparam logic [STEP_W-1:0]     STEP_RST     = 31'd131200;
	localparam logic [ITER_W-1:0]     MAX_ITER_RST = 20'd1000000;

	localparam logic signed [SQ_W:0] ESCAPE_LIMIT = (SQ_W+1)'(64'd4 << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN = 3'd0,
		REG_Y_ORIGIN = 3'd1,
		REG_X_STEP   = 3'd2,
		REG_Y_STEP   = 3'd3,
		REG_MAX_ITER = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ADD,
		B_MUL,
		B_TEST,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic [IDX_W-1:0]        column;
		logic [IDX_W-1:0]        row;
		logic signed [Q_W-1:0]   cx;
		logic signed [Q_W-1:0]   cy;
	} job_t;

	// Clamp a wide signed sum to the Q6.26 range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:Q_W-1] == '0 || v[ACC_W-1:Q_W-1] == '1) begin
			return v[Q_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			return {1'b0, {(Q_W-1){1'b1}}};
		end
	endfunction

endpackage

// ----- sv/mbm_front.sv -----
module mbm_front #(
	parameter int IMAGE_WIDTH  = mbm_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = mbm_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [mbm_pkg::IDX_W-1:0]        column,
	input  logic [mbm_pkg::IDX_W-1:0]        row,
	input  logic signed [mbm_pkg::Q_W-1:0]   x_origin,
	input  logic signed [mbm_pkg::Q_W-1:0]   y_origin,
	input  logic [mbm_pkg::STEP_W-1:0]       x_step,
	input  logic [mbm_pkg::STEP_W-1:0]       y_step,
	output logic                             job_push,
	output mbm_pkg::job_t                    job,
	input  logic                             job_full
);

	localparam int WB    = $clog2(IMAGE_WIDTH + 1);
	localparam int HB    = $clog2(IMAGE_HEIGHT + 1);
	localparam int CW    = mbm_pkg::IDX_W + WB;
	localparam int CH    = mbm_pkg::IDX_W + HB;
	localparam int PW    = mbm_pkg::IDX_W + mbm_pkg::STEP_W;
	localparam int EXT   = mbm_pkg::ACC_W - PW;
	// Rounded-up reciprocals; with CW/CH fraction bits the quotient is exact
	// for every index that fits the port.
	localparam longint XRECIP = ((longint'(1) << CW) + IMAGE_WIDTH - 1) / IMAGE_WIDTH;
	localparam longint YRECIP = ((longint'(1) << CH) + IMAGE_HEIGHT - 1) / IMAGE_HEIGHT;
	localparam int XQW   = mbm_pkg::IDX_W + CW;
	localparam int YQW   = mbm_pkg::IDX_W + CH;

	mbm_pkg::front_state_t state_q, state_d;

	logic [mbm_pkg::IDX_W-1:0] col_q, row_q, rcol_q, rrow_q;
	logic [mbm_pkg::IDX_W-1:0] cq_q, rq_q;
	logic [PW-1:0]             xprod_q, yprod_q;

	logic [XQW-1:0]            col_prod;
	logic [YQW-1:0]            row_prod;
	logic signed [mbm_pkg::ACC_W-1:0] x_sum, y_sum;
	logic                      accept;

	assign accept = push && !full;

	// Index reduction: quotient by reciprocal multiply at accept, remainder next cycle.
	assign col_prod = XQW'(column) * XQW'(XRECIP);
	assign row_prod = YQW'(row) * YQW'(YRECIP);

	assign x_sum = mbm_pkg::ACC_W'(x_origin) + $signed({{EXT{1'b0}}, xprod_q});
	assign y_sum = mbm_pkg::ACC_W'(y_origin) + $signed({{EXT{1'b0}}, yprod_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbm_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		full     = 1'b1;
		job_push = 1'b0;
		case (state_q)
			mbm_pkg::F_IDLE: begin
				full = 1'b0;
				if (push) state_d = mbm_pkg::F_MOD;
			end
			mbm_pkg::F_MOD: begin
				state_d = mbm_pkg::F_MUL;
			end
			mbm_pkg::F_MUL: begin
				state_d = mbm_pkg::F_PUSH;
			end
			mbm_pkg::F_PUSH: begin
				job_push = 1'b1;
				if (!job_full) state_d = mbm_pkg::F_IDLE;
			end
			default: state_d = mbm_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= column;
			row_q <= row;
			cq_q  <= col_prod[XQW-1:CW];
			rq_q  <= row_prod[YQW-1:CH];
		end
		if (state_q == mbm_pkg::F_MOD) begin
			rcol_q <= mbm_pkg::IDX_W'(CW'(col_q) - CW'(cq_q) * CW'(IMAGE_WIDTH));
			rrow_q <= mbm_pkg::IDX_W'(CH'(row_q) - CH'(rq_q) * CH'(IMAGE_HEIGHT));
		end
		if (state_q == mbm_pkg::F_MUL) begin
			xprod_q <= PW'(rcol_q) * PW'(x_step);
			yprod_q <= PW'(rrow_q) * PW'(y_step);
		end
	end

	assign job = '{
		column: col_q,
		row:    row_q,
		cx:     mbm_pkg::sat_q(x_sum),
		cy:     mbm_pkg::sat_q(y_sum)
	};

endmodule

// ----- sv/mbm_queue.sv -----
module mbm_queue #(
	parameter int DEPTH = mbm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  mbm_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output mbm_pkg::job_t rd_data,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mbm_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ----- sv/mbm_core.sv -----
module mbm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_empty,
	output logic                          job_pop,
	input  mbm_pkg::job_t                 job,
	input  logic [mbm_pkg::ITER_W-1:0]    max_iterations,
	output logic                          empty,
	input  logic                          pop,
	output logic [mbm_pkg::IDX_W-1:0]     pixel_column,
	output logic [mbm_pkg::IDX_W-1:0]     pixel_row,
	output logic                          in_set
);

	mbm_pkg::back_state_t state_q, state_d;

	logic signed [mbm_pkg::Q_W-1:0]    cx_q, cy_q, nx_q, ny_q;
	logic [mbm_pkg::IDX_W-1:0]         col_q, row_q;
	logic signed [mbm_pkg::PROD_W-1:0] pxx_q, pyy_q, pxy_q;
	logic [mbm_pkg::ITER_W-1:0]        iter_q;
	logic                              res_q;

	logic                              out_valid_q, out_set_q;
	logic [mbm_pkg::IDX_W-1:0]         out_col_q, out_row_q;

	logic signed [mbm_pkg::SQ_W-1:0]   sxx, syy, sxy;
	logic signed [mbm_pkg::ACC_W-1:0]  nx_sum, ny_sum;
	logic signed [mbm_pkg::SQ_W:0]     esc_sum;
	logic                              escape, last_iter, out_free, out_load;

	// Floor of the Q6.26 products is the arithmetic shift.
	assign sxx = $signed(pxx_q[mbm_pkg::PROD_W-1:mbm_pkg::FRAC_BITS]);
	assign syy = $signed(pyy_q[mbm_pkg::PROD_W-1:mbm_pkg::FRAC_BITS]);
	assign sxy = $signed(pxy_q[mbm_pkg::PROD_W-1:mbm_pkg::FRAC_BITS]);

	assign nx_sum = mbm_pkg::ACC_W'(sxx) - mbm_pkg::ACC_W'(syy) + mbm_pkg::ACC_W'(cx_q);
	assign ny_sum = (mbm_pkg::ACC_W'(sxy) <<< 1) + mbm_pkg::ACC_W'(cy_q);

	assign esc_sum   = (mbm_pkg::SQ_W+1)'(sxx) + (mbm_pkg::SQ_W+1)'(syy);
	assign escape    = esc_sum > mbm_pkg::ESCAPE_LIMIT;
	assign last_iter = (iter_q + 1'b1) == max_iterations;
	assign out_free  = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbm_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			mbm_pkg::B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = (max_iterations == '0) ? mbm_pkg::B_DONE : mbm_pkg::B_ADD;
				end
			end
			mbm_pkg::B_ADD:  state_d = mbm_pkg::B_MUL;
			mbm_pkg::B_MUL:  state_d = mbm_pkg::B_TEST;
			mbm_pkg::B_TEST: begin
				state_d = (escape || last_iter) ? mbm_pkg::B_DONE : mbm_pkg::B_ADD;
			end
			mbm_pkg::B_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = mbm_pkg::B_IDLE;
				end
			end
			default: state_d = mbm_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mbm_pkg::B_IDLE: begin
				cx_q   <= job.cx;
				cy_q   <= job.cy;
				col_q  <= job.column;
				row_q  <= job.row;
				pxx_q  <= '0;
				pyy_q  <= '0;
				pxy_q  <= '0;
				iter_q <= '0;
				res_q  <= 1'b1;
			end
			mbm_pkg::B_ADD: begin
				nx_q <= mbm_pkg::sat_q(nx_sum);
				ny_q <= mbm_pkg::sat_q(ny_sum);
			end
			mbm_pkg::B_MUL: begin
				// The squares feed the escape test and the next step; pxy feeds only the next step.
				pxx_q <= nx_q * nx_q;
				pyy_q <= ny_q * ny_q;
				pxy_q <= nx_q * ny_q;
			end
			mbm_pkg::B_TEST: begin
				iter_q <= iter_q + 1'b1;
				if (escape) res_q <= 1'b0;
			end
			default: ;
		endcase
		if (out_load) begin
			out_col_q <= col_q;
			out_row_q <= row_q;
			out_set_q <= res_q;
		end
	end

	assign empty        = !out_valid_q;
	assign pixel_column = out_col_q;
	assign pixel_row    = out_row_q;
	assign in_set       = out_set_q;

endmodule

// ----- sv/mandelbrot_membership.sv -----
// Channel   Handshake                         Payload
// -------   -------------------------------   ---------------------------------
// input     push / full, taken at push&!full  column, row
// result    empty / pop, taken at pop&!empty  pixel_column, pixel_row, in_set
// config    cfg_wr_en, no wait                cfg_index, cfg_data
//
// Front: one pixel at a time, through accept with the index quotient, remainder,
// index*step multiply and push; the push holds while the job queue is full.
// Back: each iteration runs add, three 32x32 multiplies and the escape test; a
// pixel runs at most max_iterations iterations.
// A job queue (two entries by default) sits between front and back; an output
// register holds one finished result while the back starts the next job.
// Reset clears all queues and loads the register defaults.
module mandelbrot_membership #(
	parameter int IMAGE_WIDTH  = mbm_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = mbm_pkg::IMAGE_HEIGHT_DEF,
	parameter int QUEUE_DEPTH  = mbm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [mbm_pkg::IDX_W-1:0]         column,
	input  logic [mbm_pkg::IDX_W-1:0]         row,
	output logic                              empty,
	input  logic                              pop,
	output logic [mbm_pkg::IDX_W-1:0]         pixel_column,
	output logic [mbm_pkg::IDX_W-1:0]         pixel_row,
	output logic                              in_set,
	input  logic                              cfg_wr_en,
	input  logic [mbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic signed [mbm_pkg::Q_W-1:0] x_origin_q, y_origin_q;
	logic [mbm_pkg::STEP_W-1:0]     x_step_q, y_step_q;
	logic [mbm_pkg::ITER_W-1:0]     max_iter_q;

	logic          fq_push, fq_full, fq_pop, fq_empty;
	mbm_pkg::job_t fq_wr_data, fq_rd_data;

	// Configuration: take the low bits of the data word, drop unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= mbm_pkg::X_ORIGIN_RST;
			y_origin_q <= mbm_pkg::Y_ORIGIN_RST;
			x_step_q   <= mbm_pkg::STEP_RST;
			y_step_q   <= mbm_pkg::STEP_RST;
			max_iter_q <= mbm_pkg::MAX_ITER_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mbm_pkg::REG_X_ORIGIN: x_origin_q <= cfg_data[mbm_pkg::Q_W-1:0];
				mbm_pkg::REG_Y_ORIGIN: y_origin_q <= cfg_data[mbm_pkg::Q_W-1:0];
				mbm_pkg::REG_X_STEP:   x_step_q   <= cfg_data[mbm_pkg::STEP_W-1:0];
				mbm_pkg::REG_Y_STEP:   y_step_q   <= cfg_data[mbm_pkg::STEP_W-1:0];
				mbm_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[mbm_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: reduce the indexes, form c, hand the job on.
	mbm_front #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.column   (column),
		.row      (row),
		.x_origin (x_origin_q),
		.y_origin (y_origin_q),
		.x_step   (x_step_q),
		.y_step   (y_step_q),
		.job_push (fq_push),
		.job      (fq_wr_data),
		.job_full (fq_full)
	);

	// Job queue: lets the front run ahead while the back iterates.
	mbm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_wr_data),
		.full    (fq_full),
		.rd_en   (fq_pop),
		.rd_data (fq_rd_data),
		.empty   (fq_empty)
	);

	// Back: iterate z = z*z + c, hold the result until popped.
	mbm_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_empty      (fq_empty),
		.job_pop        (fq_pop),
		.job            (fq_rd_data),
		.max_iterations (max_iter_q),
		.empty          (empty),
		.pop            (pop),
		.pixel_column   (pixel_column),
		.pixel_row      (pixel_row),
		.in_set         (in_set)
	);

endmodule

// ----- sv/mbm_checker.sv -----
module mbm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic [mbm_pkg::IDX_W-1:0]     pixel_column,
	input logic [mbm_pkg::IDX_W-1:0]     pixel_row,
	input logic                          in_set
);

	// A waiting result holds until it is popped.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_column) && $stable(pixel_row)
			&& $stable(in_set))
		else $error("result changed or vanished while stalled");

	// The result side empties only through a pop.
	a_empty_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result dropped without a pop");

	// An accepted transaction occupies the front on the next cycle.
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("front free right after an accepted transaction");

	// The front fills only by accepting a transaction.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("front became busy without a transaction");

endmodule

bind mandelbrot_membership mbm_checker u_mbm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.pixel_column (pixel_column),
	.pixel_row    (pixel_row),
	.in_set       (in_set)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import mbm_pkg::*;

	localparam int          RESET_CYCLES = 7;
	localparam int          IDLE_PCT     = 15;
	localparam int          STALL_CYCLES = 400;
	localparam int          DRAIN_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          IDX_MAX      = (1 << IDX_W) - 1;

	// Q6.26 range, and 4.0 as the escape bound on x*x + y*y
	localparam longint Q_HI      = 64'sd2147483647;
	localparam longint Q_LO      = -64'sd2147483648;
	localparam longint ESCAPE_SQ = longint'(4) << FRAC_BITS;

	// Full view: x from -2.0, y from -1.25, 2.5/1024 per pixel
	localparam logic [CFG_DATA_W-1:0] VIEW_X0   = 32'hF800_0000;
	localparam logic [CFG_DATA_W-1:0] VIEW_Y0   = 32'hFB00_0000;
	localparam logic [CFG_DATA_W-1:0] VIEW_STEP = 32'd163840;
	// Zoom near the boundary around (-0.75, 0.1)
	localparam logic [CFG_DATA_W-1:0] ZOOM_X0   = 32'hFD00_0000;
	localparam logic [CFG_DATA_W-1:0] ZOOM_Y0   = 32'h0066_6666;
	// Q6.26 extremes
	localparam logic [CFG_DATA_W-1:0] Q_MAX_BITS = 32'h7FFF_FFFF;
	localparam logic [CFG_DATA_W-1:0] Q_MIN_BITS = 32'h8000_0000;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_column;
		logic [IDX_W-1:0] pixel_row;
		logic             in_set;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [IDX_W-1:0]      column = '0;
	logic [IDX_W-1:0]      row = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [IDX_W-1:0]      pixel_column;
	logic [IDX_W-1:0]      pixel_row;
	logic                  in_set;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the view registers, starting from their reset values
	longint      view_x0   = longint'(X_ORIGIN_RST);
	longint      view_y0   = longint'(Y_ORIGIN_RST);
	longint      view_dx   = longint'(STEP_RST);
	longint      view_dy   = longint'(STEP_RST);
	int unsigned iter_cap  = 32'(MAX_ITER_RST);

	pixel_t      pixel_backlog[$];     // pixels not yet taken by the block
	verdict_t    pending_verdicts[$];  // verdicts owed, oldest first
	logic        in_taken = 1'b0;      // the offered pixel went in at the last edge
	logic        steady = 1'b0;        // suppress random idling on both sides
	logic        hold_wanted = 1'b0;   // ask the receiver for one long hold-off
	logic        hold_done = 1'b0;
	int          stall_left = 0;
	int          mismatches = 0;
	int unsigned cycle_count = 0;

	mandelbrot_membership uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.column       (column),
		.row          (row),
		.empty        (empty),
		.pop          (pop),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.in_set       (in_set),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Clamp an exact sum back into the Q6.26 range.
	function automatic longint clamp_q(input longint v);
		if (v > Q_HI) return Q_HI;
		if (v < Q_LO) return Q_LO;
		return v;
	endfunction

	// Q6.26 product, floored: the arithmetic shift rounds toward minus infinity.
	function automatic longint fix_mul(input longint a, input longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	// Run the escape-time iteration for one pixel under the shadow view.
	function automatic logic point_in_set(input logic [IDX_W-1:0] col,
			input logic [IDX_W-1:0] rw);
		longint      cx, cy, zx, zy, nx, ny;
		int unsigned steps;
		logic        escaped;
		cx = clamp_q(view_x0 + longint'(col % IMAGE_WIDTH_DEF) * view_dx);
		cy = clamp_q(view_y0 + longint'(rw % IMAGE_HEIGHT_DEF) * view_dy);
		zx = 0;
		zy = 0;
		steps = 0;
		escaped = 1'b0;
		// A zero limit runs no step at all and leaves the point inside.
		while (!escaped && steps < iter_cap) begin
			nx = clamp_q(fix_mul(zx, zx) - fix_mul(zy, zy) + cx);
			ny = clamp_q(2 * fix_mul(zx, zy) + cy);
			// Exactly 4.0 does not count as escape.
			if (fix_mul(nx, nx) + fix_mul(ny, ny) > ESCAPE_SQ) begin
				escaped = 1'b1;
			end else begin
				zx = nx;
				zy = ny;
				steps++;
			end
		end
		return !escaped;
	endfunction

	// Drive one register write for a cycle and track it in the shadow copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_X_ORIGIN: view_x0 = longint'(signed'(data));
			REG_Y_ORIGIN: view_y0 = longint'(signed'(data));
			REG_X_STEP:   view_dx = longint'(data[STEP_W-1:0]);
			REG_Y_STEP:   view_dy = longint'(data[STEP_W-1:0]);
			REG_MAX_ITER: iter_cap = 32'(data[ITER_W-1:0]);
			default: ;   // unmapped index: the block drops the write
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_view(input logic [CFG_DATA_W-1:0] x0, input logic [CFG_DATA_W-1:0] y0,
			input logic [CFG_DATA_W-1:0] dx, input logic [CFG_DATA_W-1:0] dy,
			input logic [CFG_DATA_W-1:0] iters);
		write_reg(REG_X_ORIGIN, x0);
		write_reg(REG_Y_ORIGIN, y0);
		write_reg(REG_X_STEP, dx);
		write_reg(REG_Y_STEP, dy);
		write_reg(REG_MAX_ITER, iters);
	endtask

	task automatic add_pixel(input int col, input int rw);
		pixel_t p;
		p.column = IDX_W'(col);
		p.row    = IDX_W'(rw);
		pixel_backlog.push_back(p);
	endtask

	task automatic add_random(input int count);
		repeat (count) add_pixel($urandom_range(IDX_MAX), $urandom_range(IDX_MAX));
	endtask

	// Block until every pixel went in and every verdict came back.
	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Sender: offer the oldest waiting pixel, idling now and then. Offering
	// while full is allowed; the pixel is retired only once it went in.
	always @(negedge clk) begin
		if (in_taken) pixel_backlog.delete(0);
		if (arst_n && pixel_backlog.size() != 0 &&
				(steady || $urandom_range(99) >= IDLE_PCT)) begin
			push   <= 1'b1;
			column <= pixel_backlog[0].column;
			row    <= pixel_backlog[0].row;
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: pop at random, and once hold off long enough for the block to
	// fill up and raise full against the sender.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (hold_wanted && !hold_done && pending_verdicts.size() >= 2) begin
			stall_left <= STALL_CYCLES;
			hold_done <= 1'b1;
			pop <= 1'b0;
		end else begin
			pop <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Sample both handshakes at the rising edge. Retire the outgoing result
	// first, since a pixel taken at this edge cannot be the one leaving.
	always @(posedge clk) begin : watch
		verdict_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: unexpected result: column %0d row %0d in_set %0b",
						$time, pixel_column, pixel_row, in_set);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					check_field("pixel_column", int'(want.pixel_column), int'(pixel_column));
					check_field("pixel_row", int'(want.pixel_row), int'(pixel_row));
					check_field("in_set", int'(want.in_set), int'(in_set));
				end
			end
			in_taken <= push && !full;
			if (push && !full) begin
				want.pixel_column = column;
				want.pixel_row    = row;
				want.in_set       = point_in_set(column, row);
				pending_verdicts.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d pixels and %0d verdicts outstanding",
				$time, pixel_backlog.size(), pending_verdicts.size());
			$display("** mandelbrot_membership: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset view: the four corners escape within two steps, so the
		// large reset limit costs nothing here.
		add_pixel(0, 0);
		add_pixel(IDX_MAX, 0);
		add_pixel(0, IDX_MAX);
		add_pixel(IDX_MAX, IDX_MAX);
		wait_idle();

		// Full view: corners, cardioid and pinch points, alternating bits, and
		// c = -2 where |z|^2 lands exactly on 4 and must not escape.
		set_view(VIEW_X0, VIEW_Y0, VIEW_STEP, VIEW_STEP, 64);
		add_pixel(0, 0);
		add_pixel(IDX_MAX, IDX_MAX);
		add_pixel(614, 512);
		add_pixel(512, 512);
		add_pixel(0, 512);
		add_pixel(10'h2AA, 10'h155);
		add_pixel(10'h155, 10'h2AA);
		wait_idle();

		// Zero limit: no step runs, every pixel is inside.
		write_reg(REG_MAX_ITER, 0);
		add_pixel(5, 5);
		add_pixel(IDX_MAX, 0);
		wait_idle();

		// One step only.
		write_reg(REG_MAX_ITER, 1);
		add_pixel(0, 0);
		add_pixel(614, 512);
		wait_idle();

		// Saturating origins and steps: stray bits above the step and limit
		// fields must be dropped, and writes to unmapped indexes ignored.
		set_view(Q_MIN_BITS, Q_MAX_BITS, 32'hFFFF_FFFF, Q_MAX_BITS, {12'hFFF, 20'd40});
		for (k = int'(REG_MAX_ITER) + 1; k < (1 << CFG_IDX_W); k++) begin
			write_reg(CFG_IDX_W'(k), $urandom);
		end
		add_pixel(0, 0);
		add_pixel(1, 0);
		add_pixel(1, 1);
		add_pixel(2, 2);
		add_pixel(IDX_MAX, IDX_MAX);
		wait_idle();

		// Largest limit, with c pinned at the far corner so every pixel
		// escapes on its first step.
		set_view(Q_MAX_BITS, Q_MIN_BITS, 0, 0, CFG_DATA_W'({ITER_W{1'b1}}));
		add_pixel(0, 0);
		add_pixel(IDX_MAX, IDX_MAX);
		add_pixel(10'h2AA, 10'h155);
		wait_idle();

		// Random pixels over the full view, no idling on either side.
		set_view(VIEW_X0, VIEW_Y0, VIEW_STEP, VIEW_STEP, $urandom_range(20, 300));
		steady = 1'b1;
		add_random(30);
		wait_idle();
		steady = 1'b0;

		// Random pixels with a long receiver hold-off in the middle.
		write_reg(REG_MAX_ITER, 32);
		hold_wanted = 1'b1;
		add_random(35);
		wait_idle();

		// Zoom onto the boundary, where escape times vary the most.
		set_view(ZOOM_X0 + $urandom_range(0, 1 << 20), ZOOM_Y0 + $urandom_range(0, 1 << 20),
			$urandom_range(16, 256), $urandom_range(16, 256), 500);
		add_random(20);
		wait_idle();

		// Arbitrary views.
		repeat (3) begin
			set_view($urandom, $urandom, $urandom_range(0, 1 << 22),
				$urandom_range(0, 1 << 22), $urandom_range(1, 100));
			add_random(5);
			wait_idle();
		end

		// Let any stray result surface before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("** mandelbrot_membership: PASSED **");
		end else begin
			$display("** mandelbrot_membership: FAILED **");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/mbm_pkg.sv
sv/mbm_front.sv
sv/mbm_queue.sv
sv/mbm_core.sv
sv/mandelbrot_membership.sv
sv/mbm_checker.sv
sim/tb_top.sv
